@@ hdl/lpg_pkg.sv @@
package lpg_pkg;

  // Default widths of the sample and state formats
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int STATE_WIDTH_DEF  = 24;

  // Fraction bits of the Q.15 coefficients and gains
  localparam int FRAC = 15;

  // Signed operand width of gains and coefficients at the multiplier
  localparam int GAIN_W = 18;

  localparam int LEVEL_W = 16;
  localparam int QUOT_W  = 16;

  localparam logic [LEVEL_W-1:0] LEVEL_ONE = 16'h8000;  // 1.0
  localparam logic [LEVEL_W-1:0] TENTH_Q15 = 16'd3277;  // 0.1
  localparam logic [LEVEL_W-1:0] HALF_Q15  = 16'd16384; // 0.5

  localparam logic [14:0] HP_COEFF_RST = 15'd32440;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  typedef enum logic [1:0] {
    REG_FILTER_EN  = 2'd0,
    REG_HP_EN      = 2'd1,
    REG_HP_COEFF   = 2'd2,
    REG_VOL_OFFSET = 2'd3
  } reg_idx_t;

  // Per-cycle command to the shared multiply / round / saturate unit
  typedef struct packed {
    logic mul_en;  // register a * b
    logic acc_en;  // register sat(addend + rnd(product >> 15))
  } mac_ctrl_t;

endpackage

@@ hdl/lpg_div.sv @@
// Restoring divider for the filter-mode gain:
// quot = round_half_up(level * 2^15 / (0.1 + level)), one quotient bit a cycle.
module lpg_div
  import lpg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [LEVEL_W-1:0] level,
  output logic               done,
  output logic [QUOT_W-1:0]  quot
);

  localparam int NUM_W = LEVEL_W + FRAC;
  localparam int CNT_W = $clog2(QUOT_W);

  logic [LEVEL_W-1:0] den_init;
  logic [NUM_W-1:0]   num_init;
  logic [LEVEL_W-1:0] den_r;
  logic [LEVEL_W-1:0] rem_r;
  logic [QUOT_W-1:0]  sh_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               run_r;
  logic               done_r;
  logic [LEVEL_W:0]   trial;
  logic [LEVEL_W:0]   diff;
  logic               ge;

  assign den_init = TENTH_Q15 + level;
  // level << 15 plus half the divisor gives round half up
  assign num_init = {level, {FRAC{1'b0}}} + NUM_W'(den_init >> 1);

  assign trial = {rem_r, sh_r[QUOT_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && run_r && (cnt_r == CNT_W'(QUOT_W - 1));
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(QUOT_W - 1)) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den_init;
      // high part is below the divisor, so QUOT_W steps suffice
      rem_r <= LEVEL_W'(num_init[NUM_W-1:QUOT_W]);
      sh_r  <= num_init[QUOT_W-1:0];
    end else if (run_r) begin
      rem_r <= ge ? diff[LEVEL_W-1:0] : trial[LEVEL_W-1:0];
      sh_r  <= {sh_r[QUOT_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = sh_r;

endmodule

@@ hdl/lpg_mac.sv @@
// Shared multiplier with a registered product, then round half up by 2^15,
// add and saturate to the state width.
module lpg_mac
  import lpg_pkg::*;
#(
  parameter int STATE_WIDTH = STATE_WIDTH_DEF
) (
  input  logic                          clk,
  input  mac_ctrl_t                     ctrl,
  input  logic signed [STATE_WIDTH:0]   a,
  input  logic signed [GAIN_W-1:0]      b,
  input  logic signed [STATE_WIDTH:0]   addend,
  output logic signed [STATE_WIDTH-1:0] res
);

  localparam int AW   = STATE_WIDTH + 1;
  localparam int PW   = AW + GAIN_W;
  localparam int SHW  = PW - FRAC;
  localparam int SUMW = SHW + 1;

  localparam logic signed [SUMW-1:0] SAT_HI =
    {{(SUMW-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
  localparam logic signed [SUMW-1:0] SAT_LO =
    {{(SUMW-STATE_WIDTH+1){1'b1}}, {(STATE_WIDTH-1){1'b0}}};
  localparam logic signed [PW-1:0] RND = PW'(1) << (FRAC - 1);

  logic signed [PW-1:0]          prod_r;
  logic signed [PW-1:0]          prod_rnd;
  logic signed [SUMW-1:0]        sum;
  logic signed [STATE_WIDTH-1:0] res_r;

  assign prod_rnd = prod_r + RND;
  assign sum = $signed({prod_rnd[PW-1], prod_rnd[PW-1:FRAC]})
             + $signed({{(SUMW-AW){addend[AW-1]}}, addend});

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= a * b;
    end
    if (ctrl.acc_en) begin
      priority if (sum > SAT_HI) begin
        res_r <= SAT_HI[STATE_WIDTH-1:0];
      end else if (sum < SAT_LO) begin
        res_r <= SAT_LO[STATE_WIDTH-1:0];
      end else begin
        res_r <= sum[STATE_WIDTH-1:0];
      end
    end
  end

  assign res = res_r;

endmodule

@@ hdl/low_pass_gate_step_top.sv @@
// Low-pass gate, one audio sample per request.
// Input channel: in_level (unsigned Q1.15, clamped to 1.0) and in_sample_in
// (signed Q1.(SAMPLE_WIDTH-1)), taken when in_valid is high and in_stall low.
// Result channel: out_sample_out, one result per request, offered on
// out_valid and held until a cycle with out_stall low.
// Config: APB-style write/read of filter_enable, highpass_enable,
// highpass_coeff and volume_offset at byte addresses 0, 4, 8, 12; pready is
// tied high. Write only while no request is in flight.
// Timing: the block works on one request at a time and holds in_stall high
// meanwhile. Each request steps through lowpass multiply and accumulate,
// gain multiply and accumulate, highpass multiply and accumulate (only
// with the highpass) and write-back; filter mode runs the bit-serial gain
// divider first. The next request can be taken in the cycle after the
// result is registered. All products go through one multiplier.
// A result that the receiver stalls sits in the output register; a request
// finishing behind it waits in write-back until the register frees up, and
// a new request can be accepted while a result waits.
// Reset clears both filter memories, the config registers (highpass_coeff
// to 0.99) and all handshake state.
module low_pass_gate_step_top
  import lpg_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int STATE_WIDTH  = STATE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [LEVEL_W-1:0]             in_level,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample_out,
  // config port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [CFG_AW-1:0]              paddr,
  input  logic [CFG_DW-1:0]              pwdata,
  output logic [CFG_DW-1:0]              prdata,
  output logic                           pready
);

  localparam int AW = STATE_WIDTH + 1;
  // Format conversion: state has STATE_WIDTH-2 fraction bits, samples
  // SAMPLE_WIDTH-1. XR is the up-shift into state, XL the down-shift.
  localparam int XSH = STATE_WIDTH - SAMPLE_WIDTH - 1;
  localparam int XR  = (XSH > 0) ? XSH : 0;
  localparam int XL  = (XSH < 0) ? -XSH : 0;
  localparam int W   = SAMPLE_WIDTH + STATE_WIDTH + 2;

  localparam logic [W-1:0] ONE_W = {{(W-1){1'b0}}, 1'b1};
  localparam logic [W-1:0] RND_L = (ONE_W << XL) >> 1;
  localparam logic [W-1:0] RND_R = (ONE_W << XR) >> 1;
  localparam logic signed [W-1:0] Y_HI =
    {{(W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [W-1:0] Y_LO =
    {{(W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_LP_MUL,
    S_LP_ACC,
    S_LO_MUL,
    S_LO_ACC,
    S_HI_MUL,
    S_HI_ACC,
    S_WB
  } state_t;

  state_t state_r;

  // config registers
  logic                     filter_en_r;
  logic                     hp_en_r;
  logic [14:0]              hp_coeff_r;
  logic signed [15:0]       vol_offset_r;

  // filter memories
  logic signed [STATE_WIDTH-1:0] lp_mem_r;
  logic signed [STATE_WIDTH-1:0] out_mem_r;

  // per-request working registers
  logic signed [STATE_WIDTH-1:0] x_r;
  logic signed [STATE_WIDTH-1:0] lo_r;
  logic [LEVEL_W:0]              coef_r;
  logic signed [GAIN_W-1:0]      gain_r;

  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] sample_out_r;

  logic               in_acc;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;
  logic [LEVEL_W-1:0] lvl;
  logic               div_done;
  logic [QUOT_W-1:0]  div_quot;
  logic               wb_go;

  logic signed [W-1:0]           xs;
  logic signed [W-1:0]           xw;
  logic signed [W-1:0]           hs;
  logic signed [W-1:0]           yw;
  logic signed [SAMPLE_WIDTH-1:0] y;

  mac_ctrl_t                     mac_ctrl;
  logic signed [AW-1:0]          mac_a;
  logic signed [GAIN_W-1:0]      mac_b;
  logic signed [AW-1:0]          mac_add;
  logic signed [STATE_WIDTH-1:0] mac_res;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign cfg_idx  = reg_idx_t'(paddr[3:2]);
  assign pready   = 1'b1;

  assign lvl = (in_level > LEVEL_ONE) ? LEVEL_ONE : in_level;

  // sample into state format, rounding half up when narrowing
  assign xs = {{(W-SAMPLE_WIDTH){in_sample_in[SAMPLE_WIDTH-1]}}, in_sample_in};
  assign xw = ((xs <<< XR) + $signed(RND_L)) >>> XL;

  // output value into sample format, then saturate
  assign hs = {{(W-STATE_WIDTH){mac_res[STATE_WIDTH-1]}}, mac_res};
  assign yw = ((hs + $signed(RND_R)) >>> XR) <<< XL;
  always_comb begin
    priority if (yw > Y_HI) begin
      y = Y_HI[SAMPLE_WIDTH-1:0];
    end else if (yw < Y_LO) begin
      y = Y_LO[SAMPLE_WIDTH-1:0];
    end else begin
      y = yw[SAMPLE_WIDTH-1:0];
    end
  end

  assign wb_go = (state_r == S_WB) && (!out_valid_r || !out_stall);

  // operand selection for the shared unit
  always_comb begin
    mac_ctrl = '0;
    mac_a    = '0;
    mac_b    = '0;
    mac_add  = '0;
    unique case (state_r)
      S_LP_MUL: begin
        // coef * (x - prev_lp)
        mac_ctrl.mul_en = 1'b1;
        mac_a = $signed({x_r[STATE_WIDTH-1], x_r})
              - $signed({lp_mem_r[STATE_WIDTH-1], lp_mem_r});
        mac_b = $signed(GAIN_W'(coef_r));
      end
      S_LP_ACC: begin
        mac_ctrl.acc_en = 1'b1;
        mac_add = $signed({lp_mem_r[STATE_WIDTH-1], lp_mem_r});
      end
      S_LO_MUL: begin
        // lp * gain
        mac_ctrl.mul_en = 1'b1;
        mac_a = $signed({mac_res[STATE_WIDTH-1], mac_res});
        mac_b = gain_r;
      end
      S_LO_ACC: begin
        mac_ctrl.acc_en = 1'b1;
      end
      S_HI_MUL: begin
        // highpass feedback * previous output
        mac_ctrl.mul_en = 1'b1;
        mac_a = $signed({out_mem_r[STATE_WIDTH-1], out_mem_r});
        mac_b = $signed(GAIN_W'(hp_coeff_r));
      end
      S_HI_ACC: begin
        mac_ctrl.acc_en = 1'b1;
        mac_add = $signed({lo_r[STATE_WIDTH-1], lo_r})
                - $signed({lp_mem_r[STATE_WIDTH-1], lp_mem_r});
      end
      S_IDLE, S_DIV, S_WB: begin
      end
      default: begin
      end
    endcase
  end

  lpg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc && filter_en_r),
    .level (lvl),
    .done  (div_done),
    .quot  (div_quot)
  );

  lpg_mac #(
    .STATE_WIDTH (STATE_WIDTH)
  ) u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .a      (mac_a),
    .b      (mac_b),
    .addend (mac_add),
    .res    (mac_res)
  );

  // sequencer, memories and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      lp_mem_r     <= '0;
      out_mem_r    <= '0;
      filter_en_r  <= 1'b0;
      hp_en_r      <= 1'b0;
      hp_coeff_r   <= HP_COEFF_RST;
      vol_offset_r <= '0;
    end else begin
      // a result taken while the next one is written back stays valid
      if (out_valid_r && !out_stall && !wb_go) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_FILTER_EN:  filter_en_r  <= pwdata[0];
          REG_HP_EN:      hp_en_r      <= pwdata[0];
          REG_HP_COEFF:   hp_coeff_r   <= pwdata[14:0];
          REG_VOL_OFFSET: vol_offset_r <= $signed(pwdata[15:0]);
          default: begin
          end
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            x_r <= xw[STATE_WIDTH-1:0];
            if (filter_en_r) begin
              coef_r  <= {1'b0, lvl};
              state_r <= S_DIV;
            end else begin
              coef_r  <= {1'b0, HALF_Q15} + (LEVEL_W+1)'(lvl >> 1);
              gain_r  <= $signed(GAIN_W'(lvl));
              state_r <= S_LP_MUL;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            gain_r  <= $signed(GAIN_W'(div_quot))
                     + $signed({{(GAIN_W-16){vol_offset_r[15]}}, vol_offset_r});
            state_r <= S_LP_MUL;
          end
        end
        S_LP_MUL: state_r <= S_LP_ACC;
        S_LP_ACC: state_r <= S_LO_MUL;
        S_LO_MUL: state_r <= S_LO_ACC;
        S_LO_ACC: state_r <= hp_en_r ? S_HI_MUL : S_WB;
        S_HI_MUL: begin
          lo_r    <= mac_res;
          state_r <= S_HI_ACC;
        end
        S_HI_ACC: state_r <= S_WB;
        S_WB: begin
          if (wb_go) begin
            lp_mem_r     <= hp_en_r ? lo_r : mac_res;
            out_mem_r    <= mac_res;
            sample_out_r <= y;
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FILTER_EN:  prdata = CFG_DW'(filter_en_r);
      REG_HP_EN:      prdata = CFG_DW'(hp_en_r);
      REG_HP_COEFF:   prdata = CFG_DW'(hp_coeff_r);
      REG_VOL_OFFSET: prdata = CFG_DW'($unsigned(vol_offset_r));
      default:        prdata = '0;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = sample_out_r;

`ifndef SYNTHESIS
  // an accepted request always blocks the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("request accepted but block not busy");

  // divider finishes only while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider done outside divide phase");

  // gate mode skips the divider
  a_gate_skips_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !filter_en_r) |=> (state_r == S_LP_MUL))
    else $error("gate mode request did not go to lowpass multiply");

  // write-back never overwrites a result still waiting on the channel
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    wb_go |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while stalled");
`endif

endmodule
